// ===== hdl/psc_pkg.sv =====
// Shared types, widths and constants of the pressure sensor compensation core.
package psc_pkg;

  // Field widths of the raw conversions, calibration words and results.
  localparam int RawW    = 24;
  localparam int CalW    = 16;
  localparam int CfgIdxW = 3;
  localparam int TempW   = 19;
  localparam int PressW  = 32;

  // Internal widths, sized to the value ranges of each intermediate.
  localparam int DtW      = 25;  // raw temperature minus scaled reference
  localparam int ProdW    = 42;  // dT times a calibration word
  localparam int OffW     = 36;  // offset term
  localparam int SensFullW = 35; // sensitivity term before the drop
  localparam int SensW    = 14;  // sensitivity after the right shift
  localparam int PmulW    = 39;  // raw pressure times sensitivity
  localparam int DiffW    = 40;  // product minus offset
  localparam int MagW     = 27;  // magnitude after the final shift
  localparam int DivProdW = 59;  // magnitude times the reciprocal of ten
  localparam int QuotW    = 24;  // quotient of the division by ten

  // Shift amounts and constants of the compensation formulas.
  localparam int TempShift  = 23;
  localparam int OffShift   = 7;
  localparam int SensShift  = 8;
  localparam int SensDrop   = 21;
  localparam int PressShift = 13;
  localparam int TempBase   = 2000;

  // Division by ten: multiply by ceil(2^35 / 10) and shift down by 35.
  localparam logic [31:0] DivMagic = 32'hCCCC_CCCD;
  localparam int          DivShift = 35;

  // Register indexes of the calibration words.
  typedef enum logic [CfgIdxW-1:0] {
    CAL_SENS      = 3'd0,
    CAL_OFFSET    = 3'd1,
    CAL_SENS_TC   = 3'd2,
    CAL_OFFSET_TC = 3'd3,
    CAL_REF_TEMP  = 3'd4,
    CAL_TEMP_TC   = 3'd5
  } psc_cal_idx_e;

  // One input beat: the pair of raw conversions.
  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } psc_in_t;

  // One result beat.
  typedef struct packed {
    logic signed [TempW-1:0]  temperature_centideg;
    logic signed [PressW-1:0] pressure_value;
  } psc_out_t;

  // The six calibration words as held in the register file.
  typedef struct packed {
    logic [CalW-1:0] c1;
    logic [CalW-1:0] c2;
    logic [CalW-1:0] c3;
    logic [CalW-1:0] c4;
    logic [CalW-1:0] c5;
    logic [CalW-1:0] c6;
  } psc_cal_t;

  // Hand-over from the temperature stages to the pressure stages.
  typedef struct packed {
    logic                        valid;
    logic [RawW-1:0]             d1;
    logic signed [TempW-1:0]     temp;
    logic signed [OffW-1:0]      off;
    logic signed [SensW-1:0]     sens;
  } psc_front_t;

  // Hand-over from the pressure stages to the divider.
  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic [MagW-1:0]         mag;
    logic signed [TempW-1:0] temp;
  } psc_back_t;

endpackage

// ===== hdl/psc_cal_regs.sv =====
// Calibration word register file with its write channel.
module psc_cal_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [psc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [psc_pkg::CalW-1:0]     cfg_data_i,
  output psc_pkg::psc_cal_t            cal_o
);
  import psc_pkg::*;

  psc_cal_t cal_q;

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CAL_SENS:      cal_q.c1 <= cfg_data_i;
        CAL_OFFSET:    cal_q.c2 <= cfg_data_i;
        CAL_SENS_TC:   cal_q.c3 <= cfg_data_i;
        CAL_OFFSET_TC: cal_q.c4 <= cfg_data_i;
        CAL_REF_TEMP:  cal_q.c5 <= cfg_data_i;
        CAL_TEMP_TC:   cal_q.c6 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cal_o = cal_q;

endmodule

// ===== hdl/psc_comp_front.sv =====
// Temperature stages: dT, the three dT products, temperature, offset and sensitivity.
module psc_comp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  psc_pkg::psc_in_t     in_i,
  input  psc_pkg::psc_cal_t    cal_i,
  output psc_pkg::psc_front_t  front_o
);
  import psc_pkg::*;

  // Stage 1 registers.
  logic                  s1_valid_q;
  logic [RawW-1:0]       s1_d1_q;
  logic signed [DtW-1:0] s1_dt_q;
  logic signed [DtW-1:0] s1_dt_d;

  // Stage 2 registers.
  logic                    s2_valid_q;
  logic [RawW-1:0]         s2_d1_q;
  logic signed [ProdW-1:0] s2_pt_q, s2_po_q, s2_ps_q;
  logic signed [ProdW-1:0] s2_pt_d, s2_po_d, s2_ps_d;

  // Stage 3 registers.
  logic                        s3_valid_q;
  logic [RawW-1:0]             s3_d1_q;
  logic signed [TempW-1:0]     s3_temp_q, s3_temp_d;
  logic signed [OffW-1:0]      s3_off_q, s3_off_d;
  logic signed [SensW-1:0]     s3_sens_q, s3_sens_d;
  logic signed [SensFullW-1:0] sens_full;

  // Valid bits of all three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Stage 1: difference to the scaled reference temperature.
  assign s1_dt_d = $signed({1'b0, in_i.raw_temperature}) - $signed({1'b0, cal_i.c5, 8'h00});

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s1_d1_q <= in_i.raw_pressure;
      s1_dt_q <= s1_dt_d;
    end
  end

  // Stage 2: the three products of dT with calibration words.
  assign s2_pt_d = ProdW'(s1_dt_q) * ProdW'($signed({1'b0, cal_i.c6}));
  assign s2_po_d = ProdW'(s1_dt_q) * ProdW'($signed({1'b0, cal_i.c4}));
  assign s2_ps_d = ProdW'(s1_dt_q) * ProdW'($signed({1'b0, cal_i.c3}));

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_d1_q <= s1_d1_q;
      s2_pt_q <= s2_pt_d;
      s2_po_q <= s2_po_d;
      s2_ps_q <= s2_ps_d;
    end
  end

  // Stage 3: flooring shifts and the additive terms.
  assign s3_temp_d = TempW'(s2_pt_q >>> TempShift) + TempW'(TempBase);
  assign s3_off_d  = $signed({4'b0, cal_i.c2, 16'h0000}) + OffW'(s2_po_q >>> OffShift);
  assign sens_full = $signed({4'b0, cal_i.c1, 15'h0000}) + SensFullW'(s2_ps_q >>> SensShift);
  assign s3_sens_d = SensW'(sens_full >>> SensDrop);

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_d1_q   <= s2_d1_q;
      s3_temp_q <= s3_temp_d;
      s3_off_q  <= s3_off_d;
      s3_sens_q <= s3_sens_d;
    end
  end

  assign front_o.valid = s3_valid_q;
  assign front_o.d1    = s3_d1_q;
  assign front_o.temp  = s3_temp_q;
  assign front_o.off   = s3_off_q;
  assign front_o.sens  = s3_sens_q;

endmodule

// ===== hdl/psc_comp_back.sv =====
// Pressure stages: raw pressure times sensitivity, offset removal, shift and sign split.
module psc_comp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psc_pkg::psc_front_t  front_i,
  output psc_pkg::psc_back_t   back_o
);
  import psc_pkg::*;

  // Stage 4 registers.
  logic                    s4_valid_q;
  logic signed [PmulW-1:0] s4_pmul_q, s4_pmul_d;
  logic signed [OffW-1:0]  s4_off_q;
  logic signed [TempW-1:0] s4_temp_q;

  // Stage 5 registers.
  logic                    s5_valid_q;
  logic                    s5_neg_q;
  logic [MagW-1:0]         s5_mag_q, s5_mag_d;
  logic signed [TempW-1:0] s5_temp_q;
  logic signed [DiffW-1:0] diff;
  logic signed [MagW-1:0]  shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= front_i.valid;
      s5_valid_q <= s4_valid_q;
    end
  end

  // Stage 4: scale the raw pressure by the sensitivity.
  assign s4_pmul_d = PmulW'($signed({1'b0, front_i.d1})) * PmulW'(front_i.sens);

  always_ff @(posedge clk_i) begin
    if (front_i.valid) begin
      s4_pmul_q <= s4_pmul_d;
      s4_off_q  <= front_i.off;
      s4_temp_q <= front_i.temp;
    end
  end

  // Stage 5: subtract the offset, floor shift, split into sign and magnitude.
  assign diff     = DiffW'(s4_pmul_q) - DiffW'(s4_off_q);
  assign shifted  = MagW'(diff >>> PressShift);
  assign s5_mag_d = shifted[MagW-1] ? MagW'(-shifted) : MagW'(shifted);

  always_ff @(posedge clk_i) begin
    if (s4_valid_q) begin
      s5_neg_q  <= shifted[MagW-1];
      s5_mag_q  <= s5_mag_d;
      s5_temp_q <= s4_temp_q;
    end
  end

  assign back_o.valid = s5_valid_q;
  assign back_o.neg   = s5_neg_q;
  assign back_o.mag   = s5_mag_q;
  assign back_o.temp  = s5_temp_q;

endmodule

// ===== hdl/psc_div10.sv =====
// Division by ten toward zero by reciprocal multiplication, plus the result register.
module psc_div10 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psc_pkg::psc_back_t  back_i,
  output logic                result_valid_o,
  output psc_pkg::psc_out_t   result_o
);
  import psc_pkg::*;

  logic                       s6_valid_q;
  logic                       s6_neg_q;
  logic [DivProdW-1:0]        s6_prod_q, s6_prod_d;
  logic signed [TempW-1:0]    s6_temp_q;
  logic                       s7_valid_q;
  psc_out_t                   s7_out_q, s7_out_d;
  logic [QuotW-1:0]           quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
    end else begin
      s6_valid_q <= back_i.valid;
      s7_valid_q <= s6_valid_q;
    end
  end

  // Stage 6: magnitude times the reciprocal of ten.
  assign s6_prod_d = DivProdW'(back_i.mag) * DivProdW'(DivMagic);

  always_ff @(posedge clk_i) begin
    if (back_i.valid) begin
      s6_prod_q <= s6_prod_d;
      s6_neg_q  <= back_i.neg;
      s6_temp_q <= back_i.temp;
    end
  end

  // Stage 7: take the quotient and restore the sign.
  assign quot = QuotW'(s6_prod_q >> DivShift);
  always_comb begin
    s7_out_d.temperature_centideg = s6_temp_q;
    s7_out_d.pressure_value = s6_neg_q ? -$signed(PressW'(quot)) : $signed(PressW'(quot));
  end

  always_ff @(posedge clk_i) begin
    if (s6_valid_q) begin
      s7_out_q <= s7_out_d;
    end
  end

  assign result_valid_o = s7_valid_q;
  assign result_o       = s7_out_q;

endmodule

// ===== hdl/pressure_sensor_compensation_core.sv =====
// Top level of the pressure sensor first-order compensation core.
//
// Usage: write the six calibration words through the cfg channel (index 0..5
// for C1..C6, 16 data bits; writes to other indexes are dropped). The channel
// is always ready. Write configuration only while no beat is in flight.
// Raise start with a pair of raw conversions on in_i; the beat is taken at
// every edge where start is high and busy is low. busy stays low, so a new
// beat can enter in every cycle.
// Each beat gives one result on result_o, marked by result_valid_o for one
// cycle, once the beat has passed the whole pipeline. Throughput is one beat per
// cycle, set by the seven-stage pipeline: subtract, three dT multipliers,
// shift-and-add, pressure multiplier, offset subtract and shift, reciprocal
// multiplier for the division by ten, output register.
// The receiver cannot stall; results are simply presented and must be taken.
// Reset clears all calibration words to zero and empties the pipeline.
module pressure_sensor_compensation_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  psc_pkg::psc_in_t             in_i,
  output logic                         result_valid_o,
  output psc_pkg::psc_out_t            result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [psc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [psc_pkg::CalW-1:0]     cfg_data_i
);
  import psc_pkg::*;

  localparam int Latency = 7;

  psc_cal_t   cal;
  psc_front_t front;
  psc_back_t  back;
  logic       accept;

  // The pipeline never stalls, so a beat is always taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  psc_cal_regs u_cal_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cal_o       (cal)
  );

  psc_comp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_i),
    .cal_i   (cal),
    .front_o (front)
  );

  psc_comp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .front_i (front),
    .back_o  (back)
  );

  psc_div10 u_div10 (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .back_i         (back),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Every accepted beat comes out after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency result_valid_o)
    else $error("accepted beat did not produce a result");

  // No result appears without a beat accepted the fixed latency earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, Latency))
    else $error("result without a matching input beat");

  // Compensated temperature stays within its documented range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.temperature_centideg >= -140000 &&
                        result_o.temperature_centideg <= 140000))
    else $error("temperature out of range");

endmodule

// ===== sim/pressure_sensor_compensation_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pressure sensor compensation core.
module pressure_sensor_compensation_core_tb;
  import psc_pkg::*;

  localparam logic [RawW-1:0] RawMax = '1;
  localparam logic [CalW-1:0] CalMax = '1;
  // Indexes past the last calibration word; the core drops writes there.
  localparam logic [CfgIdxW-1:0] CalSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CalSpareHi = 3'd7;
  localparam int RandomPhases  = 7;
  localparam int ItemsPerPhase = 150;
  localparam int MaxGap        = 7;
  localparam int SettleCycles  = 20;

  // Holds a copy of the calibration words, predicts each reading and checks
  // the result beats against the predictions in order.
  class reading_checker;
    psc_cal_t cal;
    psc_out_t expected_readings[$];
    int       mismatch_count;

    function new();
      cal = '0;
      mismatch_count = 0;
    endfunction

    function void write_cal(logic [CfgIdxW-1:0] idx, logic [CalW-1:0] word);
      case (idx)
        CAL_SENS:      cal.c1 = word;
        CAL_OFFSET:    cal.c2 = word;
        CAL_SENS_TC:   cal.c3 = word;
        CAL_OFFSET_TC: cal.c4 = word;
        CAL_REF_TEMP:  cal.c5 = word;
        CAL_TEMP_TC:   cal.c6 = word;
        default: ;
      endcase
    endfunction

    // First-order compensation in signed 64-bit arithmetic. The shifts floor,
    // the division by ten truncates toward zero.
    function psc_out_t compensate(psc_in_t conv);
      longint   d1, d2, c1, c2, c3, c4, c5, c6;
      longint   dt, temp, off, sens, press;
      psc_out_t reading;
      d1 = conv.raw_pressure;
      d2 = conv.raw_temperature;
      c1 = cal.c1;
      c2 = cal.c2;
      c3 = cal.c3;
      c4 = cal.c4;
      c5 = cal.c5;
      c6 = cal.c6;
      dt    = d2 - c5 * 256;
      temp  = 2000 + ((dt * c6) >>> 23);
      off   = c2 * 65536 + ((c4 * dt) >>> 7);
      sens  = c1 * 32768 + ((c3 * dt) >>> 8);
      press = (((d1 * (sens >>> 21)) - off) >>> 13) / 10;
      reading.temperature_centideg = temp[TempW-1:0];
      reading.pressure_value       = press[PressW-1:0];
      return reading;
    endfunction

    function void note_conversion(psc_in_t conv);
      expected_readings.push_back(compensate(conv));
    endfunction

    function void check_reading(psc_out_t got);
      psc_out_t want;
      if (expected_readings.size() == 0) begin
        $error("result beat with no conversion pending: temperature_centideg %0d, %s %0d",
               got.temperature_centideg, "pressure_value", got.pressure_value);
        mismatch_count++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.temperature_centideg !== want.temperature_centideg) begin
        $error("temperature_centideg: expected %0d, actual %0d",
               want.temperature_centideg, got.temperature_centideg);
        mismatch_count++;
      end
      if (got.pressure_value !== want.pressure_value) begin
        $error("pressure_value: expected %0d, actual %0d",
               want.pressure_value, got.pressure_value);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  psc_in_t             in_i;
  logic                result_valid_o;
  psc_out_t            result_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CalW-1:0]     cfg_data_i;

  reading_checker rc;

  pressure_sensor_compensation_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watch both channels and the result port at every edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) rc.write_cal(cfg_index_i, cfg_data_i);
      if (start && !busy) rc.note_conversion(in_i);
      if (result_valid_o) rc.check_reading(result_o);
    end
  end

  // Idle for the given number of cycles, then present one beat until taken.
  task automatic send_conversion(psc_in_t conv, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= conv;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold the input off until every predicted reading has come out.
  task automatic wait_readings();
    start <= 1'b0;
    do @(posedge clk_i); while (rc.pending() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CalW-1:0] word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Load all six words; the spare indexes come last so that a write that is
  // not dropped would show up as a wrong reading.
  task automatic program_cal(psc_cal_t cal, bit with_spare);
    write_reg(CAL_SENS, cal.c1);
    write_reg(CAL_OFFSET, cal.c2);
    write_reg(CAL_SENS_TC, cal.c3);
    write_reg(CAL_OFFSET_TC, cal.c4);
    write_reg(CAL_REF_TEMP, cal.c5);
    write_reg(CAL_TEMP_TC, cal.c6);
    if (with_spare) begin
      write_reg(CalSpareLo, CalW'($urandom));
      write_reg(CalSpareHi, CalW'($urandom));
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [RawW-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RawMax;
      default: return RawW'($urandom);
    endcase
  endfunction

  function automatic logic [CalW-1:0] pick_cal();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CalMax;
      default: return CalW'($urandom);
    endcase
  endfunction

  function automatic psc_in_t conversion(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
    psc_in_t conv;
    conv.raw_pressure    = d1;
    conv.raw_temperature = d2;
    return conv;
  endfunction

  // Main sequence: directed corners, then randomized calibration phases.
  initial begin
    psc_cal_t cal;
    psc_in_t  conv;
    int       gap_limit;
    int       near_ref;

    rc = new();
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    in_i        <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Calibration still at its reset value of zero.
    send_conversion(conversion('0, '0), 0);
    send_conversion(conversion(RawMax, RawMax), 0);
    wait_readings();

    // Typical calibration; the reference temperature sits above the raw
    // reading, so dT and the shifted products go negative.
    cal = {16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
    program_cal(cal, 1'b0);
    send_conversion(conversion(24'd4958179, 24'd6815414), 0);
    send_conversion(conversion('0, '0), 0);
    send_conversion(conversion(RawMax, RawMax), 0);
    send_conversion(conversion(RawMax, '0), 1);
    send_conversion(conversion('0, RawMax), 0);
    send_conversion(conversion(24'hAAAAAA, 24'h555555), 2);
    send_conversion(conversion(24'h555555, 24'hAAAAAA), 0);
    send_conversion(conversion(24'd4958179, RawW'(26646 * 256)), 0);
    send_conversion(conversion(24'd100, 24'd100), 0);
    wait_readings();

    // Every calibration word at its maximum.
    program_cal({6{CalMax}}, 1'b0);
    send_conversion(conversion('0, '0), 0);
    send_conversion(conversion(RawMax, RawMax), 0);
    send_conversion(conversion(RawMax, '0), 0);
    send_conversion(conversion('0, RawMax), 3);
    wait_readings();

    // Writes to out-of-range indexes must leave the words untouched.
    write_reg(CalSpareLo, '0);
    write_reg(CalSpareHi, '0);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send_conversion(conversion(RawMax, RawMax), 0);
    send_conversion(conversion(24'h123456, 24'h654321), 0);
    wait_readings();

    // Offset only: the pressure comes out negative.
    cal    = '0;
    cal.c2 = CalMax;
    program_cal(cal, 1'b0);
    send_conversion(conversion(RawMax, 24'd800000), 0);
    send_conversion(conversion('0, '0), 0);

    // Random phases, each with its own calibration and idle pattern.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_readings();
      cal.c1 = pick_cal();
      cal.c2 = pick_cal();
      cal.c3 = pick_cal();
      cal.c4 = pick_cal();
      cal.c5 = pick_cal();
      cal.c6 = pick_cal();
      program_cal(cal, bit'($urandom_range(0, 1)));
      gap_limit = (phase % 3 == 0) ? 0 : MaxGap;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        conv.raw_pressure = pick_raw();
        if ($urandom_range(0, 2) == 0) begin
          // Raw temperature close to the reference, so dT is small.
          near_ref = int'(cal.c5) * 256 + int'($urandom_range(0, 4095)) - 2048;
          if (near_ref < 0) near_ref = 0;
          if (near_ref > int'(RawMax)) near_ref = int'(RawMax);
          conv.raw_temperature = near_ref[RawW-1:0];
        end else begin
          conv.raw_temperature = pick_raw();
        end
        send_conversion(conv, $urandom_range(0, gap_limit));
        if ((phase == 1 && n == ItemsPerPhase / 2) || $urandom_range(0, 63) == 0)
          wait_readings();
      end
    end

    wait_readings();
    repeat (SettleCycles) @(posedge clk_i);
    if (rc.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
